// ===== hw/rtl/rbsr_pkg.sv =====
// Shared constants and operation codes for the rotating buffer.
`default_nettype none
package rbsr_pkg;

    // Default sizing
    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int FUNC_W = 2;
    localparam int POS_W  = 10;
    localparam int WORD_W = 32;
    localparam int SIZE_W = 11;
    localparam int KIND_W = 2;

    // Size register value after reset, before clamping to the depth
    localparam int SIZE_RESET = 1024;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SWAP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ROTATE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

    // Operation kinds passed from front end to back end
    localparam logic [KIND_W-1:0] OP_LOAD     = 2'd0;
    localparam logic [KIND_W-1:0] OP_SWAP     = 2'd1;
    localparam logic [KIND_W-1:0] OP_READ     = 2'd2;
    localparam logic [KIND_W-1:0] OP_BAD_READ = 2'd3;

endpackage
`default_nettype wire

// ===== hw/rtl/rbsr_fifo.sv =====
// Two-entry queue between the front end and the back end.
`default_nettype none
module rbsr_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wptr, n_wptr;
    logic         r_rptr, n_rptr;
    logic [1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];

    // pointer and count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = ~r_wptr;
        end
        if (i_pop) begin
            n_rptr = ~r_rptr;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rbsr_front.sv =====
// Front end: accepts transactions, checks positions, maps them to physical addresses.
`default_nettype none
module rbsr_front #(
    parameter int  DEPTH      = rbsr_pkg::DEPTH_DEF,
    parameter int  DATA_WIDTH = rbsr_pkg::DATA_WIDTH_DEF,
    localparam int AW         = $clog2(DEPTH),
    localparam int QW         = rbsr_pkg::KIND_W + 2 * AW + DATA_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [rbsr_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [rbsr_pkg::FUNC_W-1:0] i_func,
    input  wire logic [rbsr_pkg::POS_W-1:0]  i_pos_a,
    input  wire logic [rbsr_pkg::POS_W-1:0]  i_pos_b,
    input  wire logic [rbsr_pkg::WORD_W-1:0] i_load_value,
    input  wire logic                       i_q_full,
    output logic                            o_q_push,
    output logic [QW-1:0]                   o_q_data
);
    import rbsr_pkg::*;

    localparam int LW       = $clog2(DEPTH + 1);
    localparam int SUMW     = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam int SIZE_RST = (DEPTH < SIZE_RESET) ? DEPTH : SIZE_RESET;

    logic [LW-1:0]     r_size, n_size;
    logic [AW-1:0]     r_offset, n_offset;
    logic              accept;
    logic              pa_ok, pb_ok;
    logic [SUMW-1:0]   sum_a, sum_b, size_s;
    logic [AW-1:0]     addr_a, addr_b;
    logic [KIND_W-1:0] kind;
    logic [31:0]       cfg32;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // range checks
    assign pa_ok = 32'(i_pos_a) < 32'(r_size);
    assign pb_ok = 32'(i_pos_b) < 32'(r_size);

    // logical to physical: add offset, one compare-and-subtract
    assign size_s = SUMW'(r_size);
    assign sum_a  = SUMW'(i_pos_a) + SUMW'(r_offset);
    assign sum_b  = SUMW'(i_pos_b) + SUMW'(r_offset);
    assign addr_a = (sum_a >= size_s) ? AW'(sum_a - size_s) : AW'(sum_a);
    assign addr_b = (sum_b >= size_s) ? AW'(sum_b - size_s) : AW'(sum_b);

    // classify the transaction
    always_comb begin
        o_q_push = 1'b0;
        kind     = OP_LOAD;
        n_offset = r_offset;
        unique case (i_func)
            FUNC_LOAD: begin
                o_q_push = accept && pa_ok;
                kind     = OP_LOAD;
            end
            FUNC_SWAP: begin
                o_q_push = accept && pa_ok && pb_ok;
                kind     = OP_SWAP;
            end
            FUNC_ROTATE: begin
                if (accept) begin
                    if (r_offset == '0 || 32'(r_offset) >= 32'(r_size)) begin
                        n_offset = AW'(r_size - LW'(1));
                    end else begin
                        n_offset = r_offset - AW'(1);
                    end
                end
            end
            FUNC_READ: begin
                o_q_push = accept;
                kind     = pa_ok ? OP_READ : OP_BAD_READ;
            end
            default: begin
                o_q_push = 1'b0;
            end
        endcase
        if (i_cfg_we) begin
            n_offset = '0;
        end
    end

    assign o_q_data = {kind, addr_a, addr_b, DATA_WIDTH'(i_load_value)};

    // size register, clamped to 1..DEPTH on write
    assign cfg32 = 32'(i_cfg_wdata);
    always_comb begin
        n_size = r_size;
        if (i_cfg_we) begin
            if (cfg32 == 32'd0) begin
                n_size = LW'(1);
            end else if (cfg32 > 32'(DEPTH)) begin
                n_size = LW'(DEPTH);
            end else begin
                n_size = LW'(cfg32);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= LW'(SIZE_RST);
            r_offset <= '0;
        end else begin
            r_size   <= n_size;
            r_offset <= n_offset;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rbsr_back.sv =====
// Back end: executes queued operations on the word memory and holds the result register.
`default_nettype none
module rbsr_back #(
    parameter int  DEPTH      = rbsr_pkg::DEPTH_DEF,
    parameter int  DATA_WIDTH = rbsr_pkg::DATA_WIDTH_DEF,
    localparam int AW         = $clog2(DEPTH),
    localparam int QW         = rbsr_pkg::KIND_W + 2 * AW + DATA_WIDTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire logic [QW-1:0]               i_q_data,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [rbsr_pkg::WORD_W-1:0]      o_read_value,
    output logic                             o_bad_position
);
    import rbsr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_SW1  = 2'd2;
    localparam logic [1:0] S_SW2  = 2'd3;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [1:0]            r_state, n_state;
    logic [KIND_W-1:0]     q_kind;
    logic [AW-1:0]         q_addr_a, q_addr_b;
    logic [DATA_WIDTH-1:0] q_wdata;
    logic                  out_free;
    logic                  wen, ren;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [AW-1:0]         r_sw_a, r_sw_b;
    logic [DATA_WIDTH-1:0] r_rd_a, r_rd_b;
    logic                  r_out_valid, n_out_valid;
    logic [WORD_W-1:0]     r_out_data, n_out_data;
    logic                  r_out_bad, n_out_bad;

    // unpack queue entry
    assign q_kind   = i_q_data[QW-1 -: KIND_W];
    assign q_addr_a = i_q_data[2*AW+DATA_WIDTH-1 -: AW];
    assign q_addr_b = i_q_data[AW+DATA_WIDTH-1 -: AW];
    assign q_wdata  = i_q_data[DATA_WIDTH-1:0];

    assign out_free = !r_out_valid || i_out_ready;

    // sequencer: load in S_IDLE, read via S_RD, swap via S_SW1 and S_SW2 (one write port)
    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        wen         = 1'b0;
        ren         = 1'b0;
        waddr       = q_addr_a;
        wdata       = q_wdata;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_out_bad   = r_out_bad;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (q_kind)
                        OP_LOAD: begin
                            o_q_pop = 1'b1;
                            wen     = 1'b1;
                        end
                        OP_SWAP: begin
                            o_q_pop = 1'b1;
                            ren     = 1'b1;
                            n_state = S_SW1;
                        end
                        OP_READ: begin
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                ren     = 1'b1;
                                n_state = S_RD;
                            end
                        end
                        OP_BAD_READ: begin
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_data  = '0;
                                n_out_bad   = 1'b1;
                            end
                        end
                        default: begin
                            o_q_pop = 1'b0;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_out_valid = 1'b1;
                n_out_data  = WORD_W'(r_rd_a);
                n_out_bad   = 1'b0;
                n_state     = S_IDLE;
            end
            S_SW1: begin
                wen     = 1'b1;
                waddr   = r_sw_a;
                wdata   = r_rd_b;
                n_state = S_SW2;
            end
            S_SW2: begin
                wen     = 1'b1;
                waddr   = r_sw_b;
                wdata   = r_rd_a;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // word memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        if (ren) begin
            r_rd_a <= r_mem[q_addr_a];
            r_rd_b <= r_mem[q_addr_b];
        end
    end

    // swap addresses held for the write-back cycles
    always_ff @(posedge i_clk) begin
        if (ren) begin
            r_sw_a <= q_addr_a;
            r_sw_b <= q_addr_b;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_bad  <= n_out_bad;
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_value   = r_out_data;
    assign o_bad_position = r_out_bad;
endmodule
`default_nettype wire

// ===== hw/rtl/rotating_buffer_swap_read_top.sv =====
// Rotating word buffer with logical addressing: load, swap, rotate and read.
// Read path: queue, word read register on entering S_RD, result register; a flagged read goes
// from the queue to the result register. Back end: load in S_IDLE, swap write-back in S_SW1 and
// S_SW2 (single write port), rotate not at all. Up to 2 operations queue behind the back end.
// Reset (synchronous, active low): clears offset, queue and result; size goes to min(1024, DEPTH).
// Memory contents are not cleared; an entry must be loaded before it is read.
`default_nettype none
module rotating_buffer_swap_read_top #(
    parameter int DEPTH      = rbsr_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbsr_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [rbsr_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [rbsr_pkg::FUNC_W-1:0] i_func,
    input  wire logic [rbsr_pkg::POS_W-1:0]  i_pos_a,
    input  wire logic [rbsr_pkg::POS_W-1:0]  i_pos_b,
    input  wire logic [rbsr_pkg::WORD_W-1:0] i_load_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [rbsr_pkg::WORD_W-1:0]      o_read_value,
    output logic                             o_bad_position
);
    import rbsr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int QW = KIND_W + 2 * AW + DATA_WIDTH;

    logic          q_push, q_full, q_pop, q_valid;
    logic [QW-1:0] q_wdata, q_rdata;

    // accept and classify
    rbsr_front #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_pos_a      (i_pos_a),
        .i_pos_b      (i_pos_b),
        .i_load_value (i_load_value),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata)
    );

    // operation queue
    rbsr_fifo #(
        .W (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // execute on memory
    rbsr_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_rdata),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_value   (o_read_value),
        .o_bad_position (o_bad_position)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/rbsr_checker.sv =====
// Port-level checks for the rotating buffer top level, attached by bind.
`default_nettype none
module rbsr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [rbsr_pkg::WORD_W-1:0] o_read_value,
    input wire logic                        o_bad_position
);
    // reset empties the result register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a flagged read carries a zero word
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_position |-> o_read_value == '0)
        else $error("bad position with nonzero value");

    // stalled result stays valid
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_read_value) && $stable(o_bad_position))
        else $error("result payload changed while stalled");
endmodule

bind rotating_buffer_swap_read_top rbsr_checker u_rbsr_checker (.*);
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the rotating word buffer: load, swap, rotate and read.
`timescale 1ns / 1ps
module tb;
    import rbsr_pkg::*;

    localparam int BUF_DEPTH  = DEPTH_DEF;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_OPS  = 95;
    localparam int SETTLE     = 20;
    localparam int MAX_REPORT = 10;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos_a;
        logic [POS_W-1:0]  pos_b;
        logic [WORD_W-1:0] value;
    } t_buf_op;

    typedef struct {
        logic [WORD_W-1:0] value;
        logic              bad;
    } t_read_result;

    // DUT ports
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata    = '0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_ready;
    logic [FUNC_W-1:0] i_func         = FUNC_LOAD;
    logic [POS_W-1:0]  i_pos_a        = '0;
    logic [POS_W-1:0]  i_pos_b        = '0;
    logic [WORD_W-1:0] i_load_value   = '0;
    logic              o_out_valid;
    logic              i_out_ready    = 1'b0;
    logic [WORD_W-1:0] o_read_value;
    logic              o_bad_position;

    // Pending operations and expected read results
    t_buf_op      op_queue[$];
    t_read_result exp_reads[$];
    t_buf_op      drv_op;

    // Predicted buffer state, updated on each accepted transaction
    logic [WORD_W-1:0] buf_words [BUF_DEPTH];
    logic [POS_W-1:0]  buf_offset = '0;
    int                buf_size   = BUF_DEPTH;

    // Stimulus-side view: which physical entries hold a loaded word
    bit [BUF_DEPTH-1:0] loaded_map = '0;
    logic [POS_W-1:0]   gen_offset = '0;
    int                 gen_size   = BUF_DEPTH;

    int send_pct    = 0;
    int recv_pct    = 0;
    int mismatches  = 0;
    int ops_pushed  = 0;
    int ops_done    = 0;
    int reads_seen  = 0;
    int bad_reads   = 0;
    int size_writes = 0;

    rotating_buffer_swap_read_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_pos_a        (i_pos_a),
        .i_pos_b        (i_pos_b),
        .i_load_value   (i_load_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_value   (o_read_value),
        .o_bad_position (o_bad_position)
    );

    always #2 i_clk = ~i_clk;

    // Register value 0 acts as 1, anything above the depth as the depth
    function automatic int live_size(input logic [SIZE_W-1:0] v);
        if (v < 1) return 1;
        if (v > BUF_DEPTH) return BUF_DEPTH;
        return int'(v);
    endfunction

    // Logical position to physical entry, one compare-and-subtract
    function automatic logic [POS_W-1:0] phys_index(input logic [POS_W-1:0] pos,
                                                     input logic [POS_W-1:0] off,
                                                     input int size);
        int a;
        a = int'(pos) + int'(off);
        if (a >= size) a -= size;
        if (a >= BUF_DEPTH) a = 0;
        return POS_W'(a);
    endfunction

    // Rotate right: offset steps down, wrapping from zero to size-1
    function automatic logic [POS_W-1:0] rotated_offset(input logic [POS_W-1:0] off,
                                                         input int size);
        if (off == 0 || off >= size) return POS_W'(size - 1);
        return off - 1'b1;
    endfunction

    // Buffer predictor: applies one accepted operation, queues the expected result of a read
    task automatic apply_op(input t_buf_op op);
        logic [POS_W-1:0]  ia, ib;
        logic [WORD_W-1:0] t;
        t_read_result      res;
        case (op.func)
            FUNC_LOAD: begin
                if (op.pos_a < buf_size)
                    buf_words[phys_index(op.pos_a, buf_offset, buf_size)] = op.value;
            end
            FUNC_SWAP: begin
                if (op.pos_a < buf_size && op.pos_b < buf_size) begin
                    ia = phys_index(op.pos_a, buf_offset, buf_size);
                    ib = phys_index(op.pos_b, buf_offset, buf_size);
                    t = buf_words[ia];
                    buf_words[ia] = buf_words[ib];
                    buf_words[ib] = t;
                end
            end
            FUNC_ROTATE: begin
                buf_offset = rotated_offset(buf_offset, buf_size);
            end
            default: begin
                if (op.pos_a < buf_size) begin
                    res.value = buf_words[phys_index(op.pos_a, buf_offset, buf_size)];
                    res.bad   = 1'b0;
                end else begin
                    res.value = '0;
                    res.bad   = 1'b1;
                end
                exp_reads.push_back(res);
            end
        endcase
    endtask

    // Queue one operation and track which entries it leaves loaded
    task automatic push_op(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pa,
                           input logic [POS_W-1:0] pb, input logic [WORD_W-1:0] v);
        t_buf_op op;
        logic [POS_W-1:0] ia, ib;
        bit t;
        op.func  = func;
        op.pos_a = pa;
        op.pos_b = pb;
        op.value = v;
        op_queue.push_back(op);
        ops_pushed++;
        if (func == FUNC_LOAD && pa < gen_size) begin
            loaded_map[phys_index(pa, gen_offset, gen_size)] = 1'b1;
        end else if (func == FUNC_SWAP && pa < gen_size && pb < gen_size) begin
            ia = phys_index(pa, gen_offset, gen_size);
            ib = phys_index(pb, gen_offset, gen_size);
            t = loaded_map[ia];
            loaded_map[ia] = loaded_map[ib];
            loaded_map[ib] = t;
        end else if (func == FUNC_ROTATE) begin
            gen_offset = rotated_offset(gen_offset, gen_size);
        end
    endtask

    // In-range position, mostly a low window on large sizes
    function automatic logic [POS_W-1:0] good_pos();
        if ($urandom_range(19) == 0) return POS_W'(gen_size - 1);
        if (gen_size > 64 && $urandom_range(3) != 0) return POS_W'($urandom_range(31));
        return POS_W'($urandom_range(gen_size - 1));
    endfunction

    // Position that is out of range about one time in ten when that is possible
    function automatic logic [POS_W-1:0] pick_pos();
        if (gen_size < BUF_DEPTH && $urandom_range(9) == 0)
            return POS_W'($urandom_range(BUF_DEPTH - 1, gen_size));
        return good_pos();
    endfunction

    // One random operation; reads only target loaded entries or bad positions
    task automatic push_random_op();
        int r;
        logic [POS_W-1:0]  pa, pb;
        logic [WORD_W-1:0] v;
        bit hit;
        r  = $urandom_range(99);
        pa = pick_pos();
        pb = pick_pos();
        v  = $urandom;
        if ($urandom_range(15) == 0) v = $urandom_range(1) ? '1 : '0;
        if (r < 30) begin
            push_op(FUNC_LOAD, pa, pb, v);
        end else if (r < 50) begin
            push_op(FUNC_SWAP, pa, pb, v);
        end else if (r < 62) begin
            push_op(FUNC_ROTATE, POS_W'($urandom), POS_W'($urandom), v);
        end else if (gen_size < BUF_DEPTH && $urandom_range(9) == 0) begin
            push_op(FUNC_READ, POS_W'($urandom_range(BUF_DEPTH - 1, gen_size)),
                    POS_W'($urandom), v);
        end else begin
            hit = 1'b0;
            for (int k = 0; k < 8 && !hit; k++) begin
                pa  = good_pos();
                hit = loaded_map[phys_index(pa, gen_offset, gen_size)];
            end
            if (hit) push_op(FUNC_READ, pa, POS_W'($urandom), v);
            else     push_op(FUNC_LOAD, pa, POS_W'($urandom), v);
        end
    endtask

    // Wait until every queued transaction is accepted and all reads have come back
    task automatic wait_drained();
        while (ops_done != ops_pushed || exp_reads.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Size register write; clears the offset on both sides
    task automatic write_size(input logic [SIZE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        buf_size   = live_size(v);
        buf_offset = '0;
        gen_size   = live_size(v);
        gen_offset = '0;
        size_writes++;
    endtask

    // Driver: presents queued operations, predicts on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_op('{i_func, i_pos_a, i_pos_b, i_load_value});
                ops_done++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (op_queue.size() != 0 && $urandom_range(99) >= send_pct) begin
                    drv_op = op_queue.pop_front();
                    i_in_valid   <= 1'b1;
                    i_func       <= drv_op.func;
                    i_pos_a      <= drv_op.pos_a;
                    i_pos_b      <= drv_op.pos_b;
                    i_load_value <= drv_op.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, checks each result against the oldest expected read
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_pct);
            if (o_out_valid && i_out_ready) begin
                if (exp_reads.size() == 0) begin
                    if (mismatches < MAX_REPORT)
                        $display("%0t: unexpected result value=%h bad=%b",
                                 $time, o_read_value, o_bad_position);
                    mismatches++;
                end else begin
                    if (o_read_value !== exp_reads[0].value ||
                        o_bad_position !== exp_reads[0].bad) begin
                        if (mismatches < MAX_REPORT)
                            $display("%0t: read mismatch exp value=%h bad=%b got value=%h bad=%b",
                                     $time, exp_reads[0].value, exp_reads[0].bad,
                                     o_read_value, o_bad_position);
                        mismatches++;
                    end
                    if (exp_reads[0].bad) bad_reads++;
                    reads_seen++;
                    void'(exp_reads.pop_front());
                end
            end
        end
    end

    // Stimulus sequence
    initial begin
        logic [SIZE_W-1:0] sizes [NUM_PHASES];
        sizes = '{11'd2047, 11'd1, 11'd0, 11'd2, 11'd1025, 11'd1000,
                  SIZE_W'($urandom_range(64, 3)), 11'd1024,
                  SIZE_W'($urandom_range(300, 5)), 11'd3};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full size, extremes, swap across the ends, rotate wrap
        push_op(FUNC_LOAD,   10'd0,    10'd0,    32'h0000_0000);
        push_op(FUNC_LOAD,   10'd1023, 10'd0,    32'hFFFF_FFFF);
        push_op(FUNC_READ,   10'd0,    10'd1023, 32'h0);
        push_op(FUNC_READ,   10'd1023, 10'd0,    32'h0);
        push_op(FUNC_SWAP,   10'd0,    10'd1023, 32'h0);
        push_op(FUNC_READ,   10'd0,    10'd0,    32'h0);
        push_op(FUNC_ROTATE, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
        push_op(FUNC_READ,   10'd1,    10'd0,    32'h0);
        push_op(FUNC_READ,   10'd0,    10'd0,    32'h0);
        push_op(FUNC_SWAP,   10'd1,    10'd1,    32'h0);
        push_op(FUNC_READ,   10'd1,    10'd0,    32'h0);
        wait_drained();

        // Directed: small size, out-of-range load, swap and read, wrap of offset
        write_size(11'd4);
        push_op(FUNC_LOAD,   10'd0,    10'd0,    32'h1111_1111);
        push_op(FUNC_LOAD,   10'd1,    10'd0,    32'h2222_2222);
        push_op(FUNC_LOAD,   10'd2,    10'd0,    32'h3333_3333);
        push_op(FUNC_LOAD,   10'd3,    10'd0,    32'h4444_4444);
        push_op(FUNC_LOAD,   10'd4,    10'd0,    32'hDEAD_BEEF);
        push_op(FUNC_SWAP,   10'd0,    10'd4,    32'h0);
        push_op(FUNC_READ,   10'd4,    10'd0,    32'h0);
        push_op(FUNC_READ,   10'd1023, 10'd0,    32'h0);
        push_op(FUNC_ROTATE, 10'd0,    10'd0,    32'h0);
        push_op(FUNC_READ,   10'd0,    10'd0,    32'h0);
        push_op(FUNC_ROTATE, 10'd0,    10'd0,    32'h0);
        push_op(FUNC_READ,   10'd3,    10'd0,    32'h0);
        push_op(FUNC_SWAP,   10'd0,    10'd3,    32'h0);
        push_op(FUNC_READ,   10'd0,    10'd0,    32'h0);
        wait_drained();

        // Random phases over sizes and idle patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_size(sizes[p]);
            case (p % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 86; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 86; end
                default: begin send_pct = 29; recv_pct = 29; end
            endcase
            for (int k = 0; k < PHASE_OPS; k++) begin
                // in phase 3, sender holds off mid-phase until every read has returned
                if (p == 3 && k == PHASE_OPS / 2) wait_drained();
                push_random_op();
            end
            wait_drained();
        end

        $display("Ran %0d operations over %0d size settings, idle patterns on both sides.",
                 ops_done, size_writes);
        $display("Checked %0d read results, %0d of them out-of-range positions.",
                 reads_seen, bad_reads);
        if (mismatches == 0 && exp_reads.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d reads outstanding", mismatches, exp_reads.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout: %0d operations pending, %0d reads outstanding",
                 op_queue.size(), exp_reads.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rbsr_pkg.sv
hw/rtl/rbsr_fifo.sv
hw/rtl/rbsr_front.sv
hw/rtl/rbsr_back.sv
hw/rtl/rotating_buffer_swap_read_top.sv
hw/rtl/rbsr_checker.sv
sim/tb.sv
